// ----- hw/rtl/lgs_pkg.sv -----
package lgs_pkg;

    // fixed field widths of one beat
    localparam int unsigned ACT_W       = 2;
    localparam int unsigned ROW_W       = 5;
    localparam int unsigned COL_W       = 5;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 8;

    // neighbor count and the B3/S23 rule
    localparam int unsigned NB_W        = 4;
    localparam logic [NB_W-1:0] BIRTH_CNT   = 4'd3;
    localparam logic [NB_W-1:0] SURVIVE_CNT = 4'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ----- hw/rtl/lgs_row_cell.sv -----
module lgs_row_cell #(
    parameter int unsigned SIDE = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic [SIDE-1:0] i_row,
    output logic [SIDE-1:0] o_row
);

    logic [SIDE-1:0] r_row;
    logic [SIDE-1:0] n_row;

    always_comb begin
        n_row = i_shift ? i_row : r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

// ----- hw/rtl/lgs_rule_unit.sv -----
module lgs_rule_unit #(
    parameter int unsigned SIDE = 32
) (
    input  logic [SIDE-1:0] i_above,
    input  logic [SIDE-1:0] i_self,
    input  logic [SIDE-1:0] i_below,
    output logic [SIDE-1:0] o_next
);

    import lgs_pkg::*;

    // dead border on both sides of each row
    logic [SIDE+1:0] w_above_p;
    logic [SIDE+1:0] w_self_p;
    logic [SIDE+1:0] w_below_p;

    assign w_above_p = {1'b0, i_above, 1'b0};
    assign w_self_p  = {1'b0, i_self, 1'b0};
    assign w_below_p = {1'b0, i_below, 1'b0};

    always_comb begin
        logic [NB_W-1:0] nb;
        for (int c = 0; c < SIDE; c++) begin
            nb = NB_W'(w_above_p[c]) + NB_W'(w_above_p[c+1]) + NB_W'(w_above_p[c+2])
               + NB_W'(w_self_p[c])  + NB_W'(w_self_p[c+2])
               + NB_W'(w_below_p[c]) + NB_W'(w_below_p[c+1]) + NB_W'(w_below_p[c+2]);
            o_next[c] = (nb == BIRTH_CNT) || (i_self[c] && (nb == SURVIVE_CNT));
        end
    end

endmodule

// ----- hw/rtl/life_generation_step.sv -----
// Life (B3/S23) engine over a SIDE x SIDE grid, cleared to all dead at reset; cells
// beyond the edge count as dead. The grid sits in a chain of SIDE row cells that
// rotates one row per cycle past a head position. Every write, read or generation
// step makes one full rotation: the beat is taken in S_IDLE, the chain rotates in
// S_RUN and S_DONE posts the result once the output register is free. During a
// generation step the rule unit computes the new head row from the row above (held
// in a window register) and the row below, and the new row re-enters at the tail.
// Action code 3 skips the rotation and answers with done_res 0. A new beat is
// taken as soon as the result is in the output register, even if it has not been
// collected yet.
module life_generation_step #(
    parameter int unsigned SIDE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] row, [9:5] col, [10] cell_in, [15:11] zero
    input  logic [lgs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] action
    input  logic [lgs_pkg::ACT_W-1:0]       i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] cell_out, [1] done_res, [7:2] zero
    output logic [lgs_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import lgs_pkg::*;

    localparam int unsigned CNT_W = $clog2(SIDE);

    t_state           r_state, n_state;
    t_action          r_action, n_action;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_val, n_val;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SIDE-1:0]  r_above, n_above;
    logic             r_rd, n_rd;
    logic             r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic [SIDE-1:0] w_row   [SIDE];
    logic [SIDE-1:0] w_in    [SIDE];
    logic [SIDE-1:0] w_head;
    logic [SIDE-1:0] w_below;
    logic [SIDE-1:0] w_next;
    logic [SIDE-1:0] w_col_hit;
    logic [SIDE-1:0] w_tail;
    logic            w_shift;
    logic            w_last;
    logic            w_row_hit;
    logic            w_accept;

    // row chain: each cell takes its right neighbor, the tail takes the processed head
    for (genvar k = 0; k < SIDE; k++) begin : g_chain
        if (k == SIDE - 1) begin : g_tail
            assign w_in[k] = w_tail;
        end else begin : g_mid
            assign w_in[k] = w_row[k+1];
        end
        lgs_row_cell #(.SIDE(SIDE)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_row   (w_in[k]),
            .o_row   (w_row[k])
        );
    end

    assign w_head  = w_row[0];
    assign w_last  = (r_cnt == CNT_W'(SIDE - 1));
    assign w_below = w_last ? '0 : w_row[1];
    assign w_shift = (r_state == S_RUN);

    lgs_rule_unit #(.SIDE(SIDE)) u_rule (
        .i_above (r_above),
        .i_self  (w_head),
        .i_below (w_below),
        .o_next  (w_next)
    );

    always_comb begin
        for (int c = 0; c < SIDE; c++) begin
            w_col_hit[c] = (32'(c) == 32'(r_col));
        end
    end

    assign w_row_hit = (32'(r_cnt) == 32'(r_row));

    always_comb begin
        w_tail = w_head;
        if (r_action == ACT_STEP) begin
            w_tail = w_next;
        end else if (r_action == ACT_WRITE && w_row_hit) begin
            w_tail = (w_head & ~w_col_hit) | (w_col_hit & {SIDE{r_val}});
        end
    end

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_row    = r_row;
        n_col    = r_col;
        n_val    = r_val;
        n_cnt    = r_cnt;
        n_above  = r_above;
        n_rd     = r_rd;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action = t_action'(i_s_axis_tuser);
                    n_row    = i_s_axis_tdata[ROW_W-1:0];
                    n_col    = i_s_axis_tdata[ROW_W +: COL_W];
                    n_val    = i_s_axis_tdata[ROW_W+COL_W];
                    n_cnt    = '0;
                    n_above  = '0;
                    n_rd     = 1'b0;
                    n_state  = (t_action'(i_s_axis_tuser) == ACT_NOP) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                n_above = w_head;
                if (r_action == ACT_READ && w_row_hit) begin
                    n_rd = |(w_head & w_col_hit);
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = '0;
                    n_odata[0] = (r_action == ACT_READ) && r_rd;
                    n_odata[1] = (r_action != ACT_NOP);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_above  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_above  <= n_above;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_row    <= n_row;
        r_col    <= n_col;
        r_val    <= n_val;
        r_rd     <= n_rd;
        r_odata  <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input taken while previous beat still in work");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (32'(r_cnt) < SIDE))
        else $error("rotation counter out of range");

    a_done_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_ovalid || i_m_axis_tready)) |=>
            (o_m_axis_tvalid && (r_state == S_IDLE)))
        else $error("finished item not posted to output");

    a_read_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[1]) |-> !o_m_axis_tdata[0])
        else $error("cell_out set on an unused action");

endmodule

// ----- dv/life_step_chk.sv -----
`timescale 1ns / 1ps

module life_step_chk #(
    parameter int SIDE = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [4:0] row, [9:5] col, [10] cell_in, [15:11] zero
    input  logic [lgs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [lgs_pkg::ACT_W-1:0]       i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [0] cell_out, [1] done_res, [7:2] zero
    input  logic [lgs_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_results_due
);

    import lgs_pkg::*;

    typedef struct packed {
        logic cell_out;
        logic done_res;
    } t_cell_result;

    logic [SIDE-1:0] model_grid [SIDE];
    t_cell_result    cell_results_due [$];
    t_cell_result    oldest;
    int              fail_total = 0;

    function automatic t_cell_result predict_cell_result(
        input t_action          act,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic             cell_val
    );
        t_cell_result    res;
        logic [SIDE-1:0] prior_grid [SIDE];
        logic            on_grid;
        int              nbrs;
        res.cell_out = 1'b0;
        res.done_res = 1'b1;
        on_grid = (int'(row) < SIDE) && (int'(col) < SIDE);
        case (act)
            ACT_WRITE: begin
                if (on_grid) model_grid[row][col] = cell_val;
            end
            ACT_READ: begin
                if (on_grid) res.cell_out = model_grid[row][col];
            end
            ACT_STEP: begin
                // every cell looks at the old grid only, outside the edge is dead
                prior_grid = model_grid;
                for (int r = 0; r < SIDE; r++) begin
                    for (int c = 0; c < SIDE; c++) begin
                        nbrs = 0;
                        for (int dr = -1; dr <= 1; dr++) begin
                            for (int dc = -1; dc <= 1; dc++) begin
                                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < SIDE
                                    && c + dc >= 0 && c + dc < SIDE)
                                    nbrs += prior_grid[r + dr][c + dc];
                            end
                        end
                        model_grid[r][c] = (nbrs == BIRTH_CNT)
                            || (prior_grid[r][c] && nbrs == SURVIVE_CNT);
                    end
                end
            end
            default: begin
                res.done_res = 1'b0;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SIDE; r++) model_grid[r] = '0;
            cell_results_due.delete();
            o_results_due <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (cell_results_due.size() == 0) begin
                    $error("result beat with nothing expected: tdata %0h", i_m_tdata);
                    fail_total++;
                end else begin
                    oldest = cell_results_due.pop_front();
                    if (i_m_tdata[0] !== oldest.cell_out) begin
                        $error("cell_out mismatch: expected %0b, actual %0b",
                               oldest.cell_out, i_m_tdata[0]);
                        fail_total++;
                    end
                    if (i_m_tdata[1] !== oldest.done_res) begin
                        $error("done_res mismatch: expected %0b, actual %0b",
                               oldest.done_res, i_m_tdata[1]);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                cell_results_due.push_back(predict_cell_result(t_action'(i_s_tuser),
                    i_s_tdata[ROW_W-1:0], i_s_tdata[ROW_W+COL_W-1:ROW_W],
                    i_s_tdata[ROW_W+COL_W]));
            o_results_due <= cell_results_due.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

// ----- dv/tb_life_generation_step.sv -----
`timescale 1ns / 1ps

module tb_life_generation_step;

    import lgs_pkg::*;

    localparam int GRID_SIDE    = 32;
    localparam int RANDOM_ITEMS = 500;
    localparam int RUN_LIMIT    = 500000;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACT_W-1:0]       s_tuser  = ACT_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     fail_count;
    int                     results_due;
    int                     burst_left = 8;
    int                     cycle_cnt  = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    life_generation_step #(
        .SIDE (GRID_SIDE)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    life_step_chk #(
        .SIDE (GRID_SIDE)
    ) u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // offers one beat, then maybe ends the burst with an idle gap
    task automatic offer_item(
        input t_action          act,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic             cell_val
    );
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, cell_val, col, row};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin : stimulus
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        int               win_row;
        int               win_col;
        int               roll;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, then a step in which lone cells die
        offer_item(ACT_WRITE, 5'd0, 5'd0, 1'b1);
        offer_item(ACT_WRITE, 5'd31, 5'd31, 1'b1);
        offer_item(ACT_WRITE, 5'd0, 5'd31, 1'b1);
        offer_item(ACT_WRITE, 5'd31, 5'd0, 1'b1);
        offer_item(ACT_READ, 5'd0, 5'd0, 1'b0);
        offer_item(ACT_READ, 5'd31, 5'd31, 1'b1);
        offer_item(ACT_READ, 5'd5, 5'd5, 1'b0);
        offer_item(ACT_STEP, 5'd31, 5'd31, 1'b1);
        offer_item(ACT_READ, 5'd0, 5'd0, 1'b0);
        offer_item(ACT_READ, 5'd31, 5'd31, 1'b0);
        // blinker against the top edge loses its upper half
        offer_item(ACT_WRITE, 5'd0, 5'd10, 1'b1);
        offer_item(ACT_WRITE, 5'd0, 5'd11, 1'b1);
        offer_item(ACT_WRITE, 5'd0, 5'd12, 1'b1);
        offer_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
        offer_item(ACT_READ, 5'd1, 5'd11, 1'b0);
        offer_item(ACT_READ, 5'd0, 5'd10, 1'b0);
        // still life in the far corner
        offer_item(ACT_WRITE, 5'd30, 5'd30, 1'b1);
        offer_item(ACT_WRITE, 5'd30, 5'd31, 1'b1);
        offer_item(ACT_WRITE, 5'd31, 5'd30, 1'b1);
        offer_item(ACT_WRITE, 5'd31, 5'd31, 1'b1);
        offer_item(ACT_STEP, 5'd17, 5'd9, 1'b1);
        offer_item(ACT_READ, 5'd31, 5'd31, 1'b0);
        offer_item(ACT_NOP, 5'd21, 5'd21, 1'b1);
        offer_item(ACT_WRITE, 5'd31, 5'd31, 1'b0);
        offer_item(ACT_READ, 5'd31, 5'd31, 1'b1);

        // writes cluster in a small window so patterns actually evolve
        win_row = $urandom_range(0, GRID_SIDE - 6);
        win_col = $urandom_range(0, GRID_SIDE - 6);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    win_row = $urandom_range(0, 1) ? 0 : GRID_SIDE - 6;
                    win_col = $urandom_range(0, 1) ? 0 : GRID_SIDE - 6;
                end else begin
                    win_row = $urandom_range(0, GRID_SIDE - 6);
                    win_col = $urandom_range(0, GRID_SIDE - 6);
                end
            end
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7) begin
                row = ROW_W'(win_row + int'($urandom_range(0, 5)));
                col = COL_W'(win_col + int'($urandom_range(0, 5)));
            end else begin
                row = ROW_W'($urandom_range(0, GRID_SIDE - 1));
                col = COL_W'($urandom_range(0, GRID_SIDE - 1));
            end
            if (roll < 3)
                offer_item(ACT_NOP, row, col, 1'($urandom_range(0, 1)));
            else if (roll < 13)
                offer_item(ACT_STEP, row, col, 1'($urandom_range(0, 1)));
            else if (roll < 58)
                offer_item(ACT_WRITE, row, col, $urandom_range(0, 9) < 7);
            else
                offer_item(ACT_READ, row, col, 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (results_due != 0);
        repeat (GRID_SIDE + 8) @(posedge clk);
        if (fail_count == 0)
            $display("[life_generation_step] OK");
        else
            $display("[life_generation_step] ERROR");
        $finish;
    end

    initial begin : receiver
        int seg;
        int seg_len;
        int mode;
        int phase;
        wait (rst_n);
        for (seg = 0; ; seg++) begin
            if (seg == 5) begin
                // long hold-off so the block backs up and stalls its input
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end else begin
                seg_len = $urandom_range(16, 160);
                mode = $urandom_range(0, 3);
                for (phase = 0; phase < seg_len; phase++) begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 5) == 0);
                        default: m_tready <= (phase % 4 == 3);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[life_generation_step] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_row_cell.sv
hw/rtl/lgs_rule_unit.sv
hw/rtl/life_generation_step.sv
dv/life_step_chk.sv
dv/tb_life_generation_step.sv
